FILE: rtl/hgc_pkg.sv
// Shared types, constants and variant tables for the Hangul glyph composer.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package hgc_pkg;

    localparam int GLYPH_ROWS  = 16;
    localparam int ROW_W       = 4;
    localparam int CODE_W      = 5;
    localparam int INIT_GLYPH_W = 8;
    localparam int MED_GLYPH_W  = 7;
    localparam int FIN_GLYPH_W  = 7;

    localparam logic [CODE_W-1:0] INITIAL_LIMIT = 5'd19;
    localparam logic [CODE_W-1:0] MEDIAL_LIMIT  = 5'd21;
    localparam logic [CODE_W-1:0] FINAL_LIMIT   = 5'd27;

    localparam logic [3:0] FINAL_SET_SHIFT_INIT = 4'd5;
    localparam logic [1:0] FINAL_SET_SHIFT_MED  = 2'd2;

    localparam logic [4:0] ADVANCE_NARROW = 5'd8;
    localparam logic [4:0] ADVANCE_WIDE   = 5'd16;

    localparam logic [ROW_W-1:0] LAST_ROW_INDEX = 4'(GLYPH_ROWS - 1);

    localparam logic       OP_WRITE   = 1'b0;
    localparam logic       OP_COMPOSE = 1'b1;

    localparam logic [1:0] SEL_INITIAL = 2'd0;
    localparam logic [1:0] SEL_MEDIAL  = 2'd1;
    localparam logic [1:0] SEL_FINAL   = 2'd2;

    localparam logic [CODE_W-1:0] INIT_SPECIAL_A = 5'd1;
    localparam logic [CODE_W-1:0] INIT_SPECIAL_B = 5'd16;

    // Variant set for the initial glyph, indexed by vowel code
    localparam logic [2:0] INIT_SET_TAB [22] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd3,
        3'd3, 3'd3, 3'd1, 3'd2, 3'd4, 3'd4, 3'd4, 3'd2, 3'd1, 3'd3, 3'd0
    };

    // Variant set for the final glyph, indexed by vowel code
    localparam logic [1:0] FIN_SET_TAB [22] = '{
        2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd3, 2'd0,
        2'd0, 2'd0, 2'd3, 2'd3, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0, 2'd0
    };

    typedef struct packed {
        logic        operation;
        logic [1:0]  table_select;
        logic [11:0] row_address;
        logic [15:0] row_data;
        logic [4:0]  initial_code;
        logic [4:0]  medial_code;
        logic [4:0]  final_code;
    } hgc_in_t;

    typedef struct packed {
        logic [3:0]  row_index;
        logic [15:0] row_bits;
        logic [4:0]  advance_width;
        logic        last_row;
    } hgc_out_t;

    // One classified item as it travels from the front to the back
    typedef struct packed {
        logic                    is_compose;
        logic [1:0]              table_select;
        logic [11:0]             row_address;
        logic [15:0]             row_data;
        logic                    use_init;
        logic                    use_med;
        logic                    use_fin;
        logic [INIT_GLYPH_W-1:0] init_glyph;
        logic [MED_GLYPH_W-1:0]  med_glyph;
        logic [FIN_GLYPH_W-1:0]  fin_glyph;
        logic [4:0]              advance;
    } hgc_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } hgc_queue_status_t;

    typedef enum logic {
        BK_IDLE,
        BK_COMPOSE
    } hgc_back_state_t;

endpackage

`default_nettype wire

FILE: rtl/hgc_front.sv
// Front end: classifies an incoming item and works out glyph numbers.
// Depends on hgc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hgc_front (
    input  wire hgc_pkg::hgc_in_t  cmd,
    output hgc_pkg::hgc_job_t      job
);

    logic [4:0] init_c;
    logic [4:0] med_c;
    logic [4:0] fin_c;
    logic [3:0] init_set;
    logic [1:0] med_set;
    logic [1:0] fin_set;
    logic       has_final;

    always_comb
    begin
        // drop codes above their limit
        init_c = (cmd.initial_code > hgc_pkg::INITIAL_LIMIT) ? 5'd0 : cmd.initial_code;
        med_c  = (cmd.medial_code  > hgc_pkg::MEDIAL_LIMIT)  ? 5'd0 : cmd.medial_code;
        fin_c  = (cmd.final_code   > hgc_pkg::FINAL_LIMIT)   ? 5'd0 : cmd.final_code;
        has_final = (fin_c != 5'd0);

        init_set = {1'b0, hgc_pkg::INIT_SET_TAB[med_c]};
        fin_set  = hgc_pkg::FIN_SET_TAB[med_c];
        med_set  = ((init_c == hgc_pkg::INIT_SPECIAL_A) || (init_c == hgc_pkg::INIT_SPECIAL_B))
                   ? 2'd0 : 2'd1;
        if (has_final)
        begin
            init_set = init_set + hgc_pkg::FINAL_SET_SHIFT_INIT;
            med_set  = med_set + hgc_pkg::FINAL_SET_SHIFT_MED;
        end

        job.is_compose   = (cmd.operation == hgc_pkg::OP_COMPOSE);
        job.table_select = cmd.table_select;
        job.row_address  = cmd.row_address;
        job.row_data     = cmd.row_data;
        job.use_init     = (init_c != 5'd0);
        job.use_med      = (med_c != 5'd0);
        job.use_fin      = has_final;
        job.init_glyph   = 8'(init_c) - 8'd1
                         + 8'(init_set) * 8'(hgc_pkg::INITIAL_LIMIT);
        job.med_glyph    = 7'(med_c) - 7'd1
                         + 7'(med_set) * 7'(hgc_pkg::MEDIAL_LIMIT);
        job.fin_glyph    = 7'(fin_c) - 7'd1
                         + 7'(fin_set) * 7'(hgc_pkg::FINAL_LIMIT);
        job.advance      = (init_c == 5'd0 && med_c == 5'd0 && fin_c == 5'd0)
                           ? hgc_pkg::ADVANCE_NARROW : hgc_pkg::ADVANCE_WIDE;
    end

endmodule

`default_nettype wire

FILE: rtl/hgc_queue.sv
// Two-entry queue of classified items between front and back.
// Depends on hgc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hgc_queue (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         push,
    input  wire hgc_pkg::hgc_job_t      push_job,
    input  wire                         pop,
    output hgc_pkg::hgc_job_t           head,
    output hgc_pkg::hgc_queue_status_t  status
);

    hgc_pkg::hgc_job_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    always_comb
    begin
        do_push      = push && (count_reg != 2'd2);
        do_pop       = pop && (count_reg != 2'd0);
        wr_ptr_next  = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next  = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next   = count_reg + {1'b0, do_push} - {1'b0, do_pop};
        head         = entry_reg[rd_ptr_reg];
        status.full  = (count_reg == 2'd2);
        status.empty = (count_reg == 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hgc_back.sv
// Back end: font memories, row sequencer and result register.
// Depends on hgc_pkg; fed by hgc_queue.
`timescale 1ns / 1ps
`default_nettype none

module hgc_back #(
    parameter int INITIAL_GLYPHS = 190,
    parameter int MEDIAL_GLYPHS  = 84,
    parameter int FINAL_GLYPHS   = 108
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire hgc_pkg::hgc_job_t      head,
    input  wire hgc_pkg::hgc_queue_status_t status,
    output logic                        pop,
    output logic                        strobe,
    output hgc_pkg::hgc_out_t           result
);

    localparam int INIT_DEPTH = INITIAL_GLYPHS * hgc_pkg::GLYPH_ROWS;
    localparam int MED_DEPTH  = MEDIAL_GLYPHS * hgc_pkg::GLYPH_ROWS;
    localparam int FIN_DEPTH  = FINAL_GLYPHS * hgc_pkg::GLYPH_ROWS;
    localparam int INIT_AW    = $clog2(INIT_DEPTH);
    localparam int MED_AW     = $clog2(MED_DEPTH);
    localparam int FIN_AW     = $clog2(FIN_DEPTH);

    logic [15:0] init_mem [INIT_DEPTH];
    logic [15:0] med_mem  [MED_DEPTH];
    logic [15:0] fin_mem  [FIN_DEPTH];

    hgc_pkg::hgc_back_state_t state_reg;
    hgc_pkg::hgc_back_state_t state_next;
    hgc_pkg::hgc_job_t        job_reg;
    logic [hgc_pkg::ROW_W-1:0] row_reg;
    logic [hgc_pkg::ROW_W-1:0] row_next;

    logic wr_init;
    logic wr_med;
    logic wr_fin;
    logic issue;

    logic [INIT_AW-1:0] init_raddr;
    logic [MED_AW-1:0]  med_raddr;
    logic [FIN_AW-1:0]  fin_raddr;

    logic [15:0] rd_init_reg;
    logic [15:0] rd_med_reg;
    logic [15:0] rd_fin_reg;

    logic                      s1_valid_reg;
    logic [hgc_pkg::ROW_W-1:0] s1_row_reg;
    logic                      s1_use_init_reg;
    logic                      s1_use_med_reg;
    logic                      s1_use_fin_reg;
    logic [4:0]                s1_adv_reg;

    logic              out_valid_reg;
    hgc_pkg::hgc_out_t out_reg;
    hgc_pkg::hgc_out_t out_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hgc_pkg::BK_IDLE:
            begin
                if (!status.empty && head.is_compose)
                begin
                    state_next = hgc_pkg::BK_COMPOSE;
                end
            end
            hgc_pkg::BK_COMPOSE:
            begin
                if (row_reg == hgc_pkg::LAST_ROW_INDEX)
                begin
                    state_next = hgc_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = hgc_pkg::BK_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        pop     = 1'b0;
        issue   = 1'b0;
        wr_init = 1'b0;
        wr_med  = 1'b0;
        wr_fin  = 1'b0;
        unique case (state_reg)
            hgc_pkg::BK_IDLE:
            begin
                pop = !status.empty;
                if (!status.empty && !head.is_compose)
                begin
                    wr_init = (head.table_select == hgc_pkg::SEL_INITIAL)
                              && (32'(head.row_address) < INIT_DEPTH);
                    wr_med  = (head.table_select == hgc_pkg::SEL_MEDIAL)
                              && (32'(head.row_address) < MED_DEPTH);
                    wr_fin  = (head.table_select == hgc_pkg::SEL_FINAL)
                              && (32'(head.row_address) < FIN_DEPTH);
                end
            end
            hgc_pkg::BK_COMPOSE:
            begin
                issue = 1'b1;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        row_next = row_reg;
        if (pop)
        begin
            row_next = '0;
        end
        else if (issue)
        begin
            row_next = row_reg + 4'd1;
        end
        init_raddr = INIT_AW'({job_reg.init_glyph, row_reg});
        med_raddr  = MED_AW'({job_reg.med_glyph, row_reg});
        fin_raddr  = FIN_AW'({job_reg.fin_glyph, row_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hgc_pkg::BK_IDLE;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            s1_valid_reg  <= issue;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head;
        end
        s1_row_reg      <= row_reg;
        s1_use_init_reg <= job_reg.use_init;
        s1_use_med_reg  <= job_reg.use_med;
        s1_use_fin_reg  <= job_reg.use_fin;
        s1_adv_reg      <= job_reg.advance;
        out_reg         <= out_next;
    end

    // font memories: one write or one read per cycle each
    always_ff @(posedge clk)
    begin
        if (wr_init)
        begin
            init_mem[head.row_address[INIT_AW-1:0]] <= head.row_data;
        end
        if (issue && job_reg.use_init)
        begin
            rd_init_reg <= init_mem[init_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_med)
        begin
            med_mem[head.row_address[MED_AW-1:0]] <= head.row_data;
        end
        if (issue && job_reg.use_med)
        begin
            rd_med_reg <= med_mem[med_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fin)
        begin
            fin_mem[head.row_address[FIN_AW-1:0]] <= head.row_data;
        end
        if (issue && job_reg.use_fin)
        begin
            rd_fin_reg <= fin_mem[fin_raddr];
        end
    end

    // mask out unused parts and merge
    always_comb
    begin
        out_next.row_index     = s1_row_reg;
        out_next.row_bits      = (s1_use_init_reg ? rd_init_reg : 16'd0)
                               | (s1_use_med_reg  ? rd_med_reg  : 16'd0)
                               | (s1_use_fin_reg  ? rd_fin_reg  : 16'd0);
        out_next.advance_width = s1_adv_reg;
        out_next.last_row      = (s1_row_reg == hgc_pkg::LAST_ROW_INDEX);
        strobe = out_valid_reg;
        result = out_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/hangul_glyph_composer.sv
// Top level of the Hangul glyph composer: front, item queue and back end.
// Depends on hgc_pkg, hgc_front, hgc_queue and hgc_back.
`timescale 1ns / 1ps
`default_nettype none

// Hangul syllable generator built on three jamo font memories (initial,
// medial, final; 190, 84 and 108 glyphs of 16 rows). An item is taken when
// start is high and busy is low. A write item (operation 0) stores one
// 16-bit font row in the same cycle as it leaves the queue and yields
// nothing. A compose item (operation 1) yields 16 results, top row first,
// each on the result port for one cycle with strobe high; the receiver
// cannot hold them off, so take every strobed row. The back end fetches a
// compose from the queue, then reads one font row per cycle, set by the
// single read port of each font memory; the first row passes the job,
// font read and result registers. A two-entry queue sits between the
// front and back, so up to two further items can be taken while a glyph is
// being emitted; busy rises when that queue is full. Only read font entries
// that have been written: memories are not cleared after reset.

module hangul_glyph_composer #(
    parameter int INITIAL_GLYPHS = 190,
    parameter int MEDIAL_GLYPHS  = 84,
    parameter int FINAL_GLYPHS   = 108
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    output logic                    busy,
    input  wire hgc_pkg::hgc_in_t   cmd,
    output logic                    strobe,
    output hgc_pkg::hgc_out_t       result
);

    hgc_pkg::hgc_job_t          front_job;
    hgc_pkg::hgc_job_t          queue_head;
    hgc_pkg::hgc_queue_status_t queue_status;
    logic                       queue_pop;
    logic                       take;

    // take an item whenever the queue has room
    assign busy = queue_status.full;
    assign take = start && !queue_status.full;

    // classify the item and work out its glyph numbers
    hgc_front u_front (
        .cmd (cmd),
        .job (front_job)
    );

    // hold classified items until the back end is free
    hgc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (take),
        .push_job (front_job),
        .pop      (queue_pop),
        .head     (queue_head),
        .status   (queue_status)
    );

    // carry out writes and stream composed rows
    hgc_back #(
        .INITIAL_GLYPHS (INITIAL_GLYPHS),
        .MEDIAL_GLYPHS  (MEDIAL_GLYPHS),
        .FINAL_GLYPHS   (FINAL_GLYPHS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (queue_head),
        .status (queue_status),
        .pop    (queue_pop),
        .strobe (strobe),
        .result (result)
    );

endmodule

`default_nettype wire
